[rtl/frcd_pkg.sv]
// Package for the FIFO-replacement cache directory: function codes,
// the queued request word and the result word. No dependencies.
package frcd_pkg;

  localparam int unsigned FUNC_W = 3;
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned SLOT_W = 8;
  localparam int unsigned AGE_W  = 32;
  localparam logic [AGE_W-1:0] AGE_NONE = 32'hFFFF_FFFF;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD    = 3'd0,
    FN_LOOKUP = 3'd1,
    FN_FLUSH  = 3'd2,
    FN_FETCH  = 3'd3,
    FN_DONE   = 3'd4,
    FN_NOP    = 3'd7
  } func_e;

  // Classified request handed from front to back
  typedef struct packed {
    func_e             func;
    logic [KEY_W-1:0]  key;
    logic              prio_req;
    logic              prio_only;
    logic [SLOT_W-1:0] done_slot;
    logic              load_ok;
  } req_t;

  // Result word
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic              was_present;
  } res_t;

endpackage

[rtl/frcd_front.sv]
// Front end: accepts request words, classifies the function code and
// buffers them in a short queue. Depends on frcd_pkg.
module frcd_front #(
  parameter int unsigned TAG_BITS = 64,
  parameter int unsigned DEPTH    = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [2:0]            func_i,
  input  logic [63:0]           key_i,
  input  logic                  priority_req_i,
  input  logic                  priority_only_i,
  input  logic [7:0]            done_slot_i,
  input  logic                  load_ok_i,
  output logic                  req_valid_o,
  input  logic                  req_take_i,
  output frcd_pkg::req_t        req_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  frcd_pkg::req_t q_mem [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;
  frcd_pkg::req_t in_req;
  frcd_pkg::func_e fn;
  logic do_push, do_pop;

  // Classify: unused codes collapse to a no-op, key masked to the tag width
  always_comb begin
    case (func_i)
      frcd_pkg::FN_ADD:    fn = frcd_pkg::FN_ADD;
      frcd_pkg::FN_LOOKUP: fn = frcd_pkg::FN_LOOKUP;
      frcd_pkg::FN_FLUSH:  fn = frcd_pkg::FN_FLUSH;
      frcd_pkg::FN_FETCH:  fn = frcd_pkg::FN_FETCH;
      frcd_pkg::FN_DONE:   fn = frcd_pkg::FN_DONE;
      default: fn = frcd_pkg::FN_NOP;
    endcase
    in_req.func      = fn;
    in_req.key       = '0;
    in_req.key[TAG_BITS-1:0] = key_i[TAG_BITS-1:0];
    in_req.prio_req  = priority_req_i;
    in_req.prio_only = priority_only_i;
    in_req.done_slot = done_slot_i;
    in_req.load_ok   = load_ok_i;
  end

  assign full_o      = (cnt_q == (PW+1)'(DEPTH));
  assign req_valid_o = (cnt_q != '0);
  assign req_o       = q_mem[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = req_take_i && req_valid_o;

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_q] <= in_req;
    end
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule

[rtl/frcd_back.sv]
// Back end: scans the slot directory one slot per cycle and carries out
// each request; result held in an output register. Depends on frcd_pkg.
module frcd_back #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_take_o,
  input  frcd_pkg::req_t req_i,
  output logic           res_valid_o,
  input  logic           res_take_i,
  output frcd_pkg::res_t res_o
);

  localparam int unsigned IW = $clog2(ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_READ, ST_CMP, ST_WRITE, ST_OUT
  } state_e;

  // Tag and age memories, one read port each
  logic [63:0]                 tag_mem [ENTRIES];
  logic [frcd_pkg::AGE_W-1:0]  age_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_q, loaded_q, prio_q;

  state_e state_q;
  frcd_pkg::req_t req_q;
  logic [IW-1:0] idx_q, last_idx_q;
  logic [IW:0]   cnt_q;
  logic [63:0]   tag_rd_q;
  logic [frcd_pkg::AGE_W-1:0] age_rd_q, min_age_q, age_ctr_q;
  logic          hit_q, empty_hit_q, rd_valid_q;
  logic [IW-1:0] hit_idx_q, empty_idx_q, min_idx_q;
  logic          busy_q;
  logic [IW-1:0] busy_slot_q;
  frcd_pkg::res_t res_q;
  frcd_pkg::res_t res_out_q;
  logic          res_valid_q;
  logic [IW-1:0] tgt;
  logic          cand;
  logic          done_match;
  logic          out_load;

  assign req_take_o  = (state_q == ST_IDLE) && req_valid_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_out_q;

  // Finished word moves to the output register once that one is free or taken
  assign out_load = (state_q == ST_OUT) && (!res_valid_q || res_take_i);

  // Load-done addresses only slots reachable through the 8-bit slot field
  assign done_match = busy_q && ({{(32-IW){1'b0}}, busy_slot_q} ==
                      {24'd0, req_q.done_slot}) && (32'(req_q.done_slot) < 32'(ENTRIES));

  // Fetch candidate at the current slot
  assign cand = valid_q[idx_q] && !loaded_q[idx_q] && (!req_q.prio_only || prio_q[idx_q]);

  assign tgt = empty_hit_q ? empty_idx_q : min_idx_q;

  // Memory read port, registered
  always_ff @(posedge clk_i) begin
    tag_rd_q <= tag_mem[idx_q];
    age_rd_q <= age_mem[idx_q];
    if (state_q == ST_WRITE && req_q.func == frcd_pkg::FN_ADD && !hit_q) begin
      tag_mem[tgt] <= req_q.key;
      age_mem[tgt] <= age_ctr_q;
    end
  end

  // Sequencer: add/lookup scan with a registered read pipeline, fetch scans bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= '0;
      idx_q       <= '0;
      last_idx_q  <= '0;
      cnt_q       <= '0;
      rd_valid_q  <= 1'b0;
      hit_q       <= 1'b0;
      empty_hit_q <= 1'b0;
      hit_idx_q   <= '0;
      empty_idx_q <= '0;
      min_idx_q   <= '0;
      min_age_q   <= frcd_pkg::AGE_NONE;
      age_ctr_q   <= '0;
      busy_q      <= 1'b0;
      busy_slot_q <= '0;
      valid_q     <= '0;
      loaded_q    <= '0;
      prio_q      <= '0;
      res_q       <= '0;
      res_out_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      // Output register: load a finished word, or drop the taken one
      if (out_load) begin
        res_valid_q <= 1'b1;
        res_out_q   <= res_q;
      end else if (res_take_i && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_valid_i) begin
            req_q       <= req_i;
            idx_q       <= '0;
            cnt_q       <= '0;
            rd_valid_q  <= 1'b0;
            hit_q       <= 1'b0;
            empty_hit_q <= 1'b0;
            min_idx_q   <= '0;
            min_age_q   <= frcd_pkg::AGE_NONE;
            res_q       <= '0;
            state_q     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          case (req_q.func)
            frcd_pkg::FN_ADD, frcd_pkg::FN_LOOKUP: begin
              // read issued at idx_q, data compared next cycle
              rd_valid_q <= (cnt_q < (IW+1)'(ENTRIES));
              last_idx_q <= idx_q;
              if (cnt_q < (IW+1)'(ENTRIES)) begin
                idx_q <= idx_q + 1'b1;
                cnt_q <= cnt_q + 1'b1;
              end
              if (rd_valid_q && valid_q[last_idx_q] && !hit_q) begin
                if (req_q.func == frcd_pkg::FN_ADD) begin
                  if (tag_rd_q == req_q.key) begin
                    hit_q <= 1'b1;
                    hit_idx_q <= last_idx_q;
                  end
                  if (age_rd_q < min_age_q) begin
                    min_age_q <= age_rd_q;
                    min_idx_q <= last_idx_q;
                  end
                end else if (!(busy_q && busy_slot_q == last_idx_q) &&
                             tag_rd_q == req_q.key) begin
                  hit_q <= 1'b1;
                  hit_idx_q <= last_idx_q;
                end
              end
              if (rd_valid_q && !valid_q[last_idx_q] && !empty_hit_q) begin
                empty_hit_q <= 1'b1;
                empty_idx_q <= last_idx_q;
              end
              if (!rd_valid_q && cnt_q == (IW+1)'(ENTRIES)) begin
                state_q <= ST_WRITE;
              end
            end
            frcd_pkg::FN_FETCH: begin
              if (busy_q) begin
                state_q <= ST_OUT;
              end else if (cand) begin
                busy_q      <= 1'b1;
                busy_slot_q <= idx_q;
                res_q.found <= 1'b1;
                res_q.slot  <= 8'(idx_q);
                state_q     <= ST_OUT;
              end else if (cnt_q == (IW+1)'(ENTRIES-1)) begin
                state_q <= ST_OUT;
              end else begin
                idx_q <= idx_q + 1'b1;
                cnt_q <= cnt_q + 1'b1;
              end
            end
            frcd_pkg::FN_FLUSH: begin
              valid_q   <= '0;
              loaded_q  <= '0;
              prio_q    <= '0;
              age_ctr_q <= '0;
              busy_q    <= 1'b0;
              state_q   <= ST_OUT;
            end
            frcd_pkg::FN_DONE: begin
              if (done_match) begin
                prio_q[busy_slot_q] <= 1'b0;
                if (req_q.load_ok) begin
                  loaded_q[busy_slot_q] <= 1'b1;
                end else begin
                  valid_q[busy_slot_q] <= 1'b0;
                end
                busy_q      <= 1'b0;
                res_q.found <= 1'b1;
                res_q.slot  <= req_q.done_slot;
              end
              state_q <= ST_OUT;
            end
            default: state_q <= ST_OUT;
          endcase
        end
        ST_WRITE: begin
          if (req_q.func == frcd_pkg::FN_ADD) begin
            if (hit_q) begin
              res_q.was_present <= 1'b1;
              res_q.slot        <= 8'(hit_idx_q);
            end else begin
              // flushed ages are reset to zero logically: age memory holds stale
              // values only in invalid slots, which are never compared
              valid_q[tgt]  <= 1'b1;
              loaded_q[tgt] <= 1'b0;
              prio_q[tgt]   <= req_q.prio_req;
              if (busy_q && busy_slot_q == tgt) begin
                busy_q <= 1'b0;
              end
              age_ctr_q     <= age_ctr_q + 1'b1;
              res_q.evicted <= !empty_hit_q;
              res_q.slot    <= 8'(tgt);
            end
          end else if (hit_q) begin
            res_q.slot  <= 8'(hit_idx_q);
            res_q.found <= loaded_q[hit_idx_q];
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/fifo_replacement_cache_directory_unit.sv]
// Top level of the FIFO-replacement cache directory: front queue and
// back-end scanner. Depends on frcd_pkg, frcd_front, frcd_back.
//
// Usage: push a request word (func, key, priority_req, priority_only,
// done_slot, load_ok) while full is low. Each word produces exactly one
// result word (found, slot, evicted, was_present), shown while empty is
// low and taken with pop.
// Add and lookup make one tag/age memory read per slot plus the read
// pipeline; fetch next checks one slot bit per cycle; flush, load done
// and unused codes do not scan the slots.
// One request is worked on at a time; the front queue holds two more.
// Reset clears every valid, loaded and priority bit, the age counter and
// the pending load; tag and age memories are not cleared.
// When the receiver stalls, the output register holds the oldest word,
// the back end finishes the next request and waits with it; the front
// queue keeps accepting until full.
module fifo_replacement_cache_directory_unit #(
  parameter int unsigned ENTRIES  = 256,
  parameter int unsigned TAG_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  func_i,
  input  logic [63:0] key_i,
  input  logic        priority_req_i,
  input  logic        priority_only_i,
  input  logic [7:0]  done_slot_i,
  input  logic        load_ok_i,
  output logic        empty,
  input  logic        pop,
  output logic        found_o,
  output logic [7:0]  slot_o,
  output logic        evicted_o,
  output logic        was_present_o
);

  frcd_pkg::req_t req;
  frcd_pkg::res_t res;
  logic req_valid, req_take, res_valid;

  frcd_front #(.TAG_BITS(TAG_BITS), .DEPTH(2)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .func_i, .key_i, .priority_req_i, .priority_only_i, .done_slot_i, .load_ok_i,
    .req_valid_o(req_valid), .req_take_i(req_take), .req_o(req)
  );

  frcd_back #(.ENTRIES(ENTRIES)) u_back (
    .clk_i, .rst_ni,
    .req_valid_i(req_valid), .req_take_o(req_take), .req_i(req),
    .res_valid_o(res_valid), .res_take_i(pop), .res_o(res)
  );

  assign empty         = !res_valid;
  assign found_o       = res.found;
  assign slot_o        = res.slot;
  assign evicted_o     = res.evicted;
  assign was_present_o = res.was_present;

endmodule
